>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while reset is high.
`define SRPG_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: check failed");

// Assertion that also holds across reset.
`define SRPG_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");

`endif

>>> rtl/srpg_pkg.sv
// Shared types and constants of the servo ramp pulse generator.
`timescale 1ns / 1ps

package srpg_pkg;

  localparam int ANGLE_W   = 8;
  localparam int RAMP_W    = 16;
  localparam int PULSE_W   = 12;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 3;

  localparam int ANGLE_HALF = 90;
  localparam int ANGLE_SPAN = 180;

  localparam logic [ANGLE_W-1:0] LOWEST_RESET   = ANGLE_W'(-90);
  localparam logic [ANGLE_W-1:0] HIGHEST_RESET  = ANGLE_W'(90);
  localparam int                 SHORTEST_INIT  = 150;
  localparam int                 LONGEST_INIT   = 600;
  localparam logic [PULSE_W-1:0] SHORTEST_RESET = PULSE_W'(SHORTEST_INIT);
  localparam logic [PULSE_W-1:0] LONGEST_RESET  = PULSE_W'(LONGEST_INIT);
  localparam logic [PULSE_W-1:0] PULSE_MID_RESET =
    PULSE_W'(SHORTEST_INIT + (LONGEST_INIT - SHORTEST_INIT) / 2);

  localparam logic CMD_SET  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_LOWEST   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HIGHEST  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_SHORTEST = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_LONGEST  = CFG_IDX_W'(3);

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_EVAL      = 8'b0000_0010,
    S_STEP_DIV  = 8'b0000_0100,
    S_MAP_OFF   = 8'b0000_1000,
    S_MAP_MUL   = 8'b0001_0000,
    S_MAP_START = 8'b0010_0000,
    S_MAP_DIV   = 8'b0100_0000,
    S_FINISH    = 8'b1000_0000
  } state_t;

endpackage

>>> rtl/srpg_serial_div.sv
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module srpg_serial_div #(
  parameter int DW = 24,
  parameter int VW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CNT_W = $clog2(DW + 1);

  logic             busy;
  logic [CNT_W-1:0] count;
  logic [VW-1:0]    rem;
  logic [VW-1:0]    dvs;
  logic [DW-1:0]    quo;
  logic [VW:0]      trial;
  logic             fits;

  assign trial    = {rem, quo[DW-1]};
  assign fits     = trial >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(DW);
      end else if (busy) begin
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= fits ? VW'(trial - {1'b0, dvs}) : trial[VW-1:0];
      quo <= {quo[DW-2:0], fits};
    end
  end

endmodule

>>> rtl/servo_ramp_pulse_generator.sv
// Servo ramp pulse generator top level.
// Input channel (in_valid/in_ready) takes one item: command, goal_angle, ramp_ms.
// A set-target item checks goal_angle against the angle limits and, if it is
// taken, works out the step per tick; with a nonzero difference and ramp_ms it
// does a serial divide of the angle difference by ramp_ms. A tick item not yet
// at the target moves the angle one step, clamps it at the target and maps it
// onto the pulse range with one multiply and a serial divide by 180.
// Output channel (out_valid/out_ready) gives one item per input item:
// status, pulse_length, turning, pulse_written.
// One item is worked on at a time; the next is taken in the cycle after the result
// is loaded. The serial divider is DW = max(FRACTION_BITS + 8, 20) bits wide; its
// run takes up most of the time of a set-target item that divides and of a moving
// tick, and an item that needs no divide goes straight from evaluation to finish.
// The output register holds a finished item while out_ready is low; a new input
// item is taken meanwhile and waits in its last step until the register frees.
// Reset (rst, synchronous) restores the default limits and pulse range, puts
// the angle and target at zero degrees and the pulse at the range midpoint.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once.
`timescale 1ns / 1ps

module servo_ramp_pulse_generator #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                command,
  input  logic signed [srpg_pkg::ANGLE_W-1:0] goal_angle,
  input  logic [srpg_pkg::RAMP_W-1:0]         ramp_ms,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                status,
  output logic [srpg_pkg::PULSE_W-1:0]        pulse_length,
  output logic                                turning,
  output logic                                pulse_written,
  input  logic                                cfg_we,
  input  logic [srpg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [srpg_pkg::CFG_W-1:0]          cfg_data
);

  localparam int AW   = srpg_pkg::ANGLE_W;
  localparam int PW   = srpg_pkg::PULSE_W;
  localparam int CW   = FRACTION_BITS + AW;
  localparam int DFW  = CW + 1;
  localparam int NW   = CW + 2;
  localparam int OW   = CW + 1;
  localparam int PRW  = PW + CW;
  localparam int MAPW = PW + AW;
  localparam int DW   = (CW > MAPW) ? CW : MAPW;

  localparam logic signed [OW-1:0] HALF_FX = OW'(srpg_pkg::ANGLE_HALF) << FRACTION_BITS;
  localparam logic [CW-1:0]        FULL_FX = CW'(srpg_pkg::ANGLE_SPAN) << FRACTION_BITS;

  srpg_pkg::state_t state;

  logic signed [AW-1:0]  lowest_angle;
  logic signed [AW-1:0]  highest_angle;
  logic [PW-1:0]         shortest_pulse;
  logic [PW-1:0]         longest_pulse;

  logic signed [CW-1:0]  current_angle;
  logic signed [AW-1:0]  target_angle;
  logic signed [DFW-1:0] step_per_tick;
  logic [PW-1:0]         pulse_now;

  logic                  cmd_q;
  logic signed [AW-1:0]  goal_q;
  logic [srpg_pkg::RAMP_W-1:0] ramp_q;
  logic                  diff_neg;
  logic                  span_neg;
  logic [CW-1:0]         off_q;
  logic [PRW-1:0]        product;

  logic                  res_status;
  logic                  res_turning;
  logic                  res_written;

  logic signed [CW-1:0]  target_fx;
  logic signed [CW-1:0]  goal_fx;
  logic signed [DFW-1:0] diff;
  logic [DFW-1:0]        diff_mag;
  logic                  in_range;
  logic                  at_target;
  logic                  moving_up;
  logic signed [NW-1:0]  sum;
  logic signed [CW-1:0]  next_angle;
  logic signed [OW-1:0]  off_sum;
  logic [CW-1:0]         off_clamped;
  logic signed [PW:0]    span;
  logic [PW-1:0]         span_mag;

  logic                  div_start;
  logic                  div_done;
  logic [DW-1:0]         div_dividend;
  logic [srpg_pkg::RAMP_W-1:0] div_divisor;
  logic [DW-1:0]         div_quotient;
  logic [CW-1:0]         step_q;
  logic [CW-1:0]         step_fix;
  logic [PW-1:0]         map_q;
  logic                  out_load;

  assign target_fx = $signed({target_angle, {FRACTION_BITS{1'b0}}});
  assign goal_fx   = $signed({goal_q, {FRACTION_BITS{1'b0}}});
  assign diff      = DFW'(goal_fx) - DFW'(current_angle);
  assign diff_mag  = diff[DFW-1] ? DFW'(-diff) : diff;
  assign in_range  = !(goal_q > highest_angle || goal_q < lowest_angle);
  assign at_target = current_angle == target_fx;
  assign moving_up = target_fx > current_angle;
  assign sum       = NW'(current_angle) + NW'(step_per_tick);

  always_comb begin
    next_angle = sum[CW-1:0];
    if (moving_up) begin
      if (sum >= NW'(target_fx) || step_per_tick <= 0) begin
        next_angle = target_fx;
      end
    end else begin
      if (sum <= NW'(target_fx) || step_per_tick >= 0) begin
        next_angle = target_fx;
      end
    end
  end

  assign off_sum = OW'(current_angle) + HALF_FX;

  always_comb begin
    if (off_sum[OW-1]) begin
      off_clamped = '0;
    end else if (off_sum[CW-1:0] > FULL_FX) begin
      off_clamped = FULL_FX;
    end else begin
      off_clamped = off_sum[CW-1:0];
    end
  end

  assign span     = $signed({1'b0, longest_pulse}) - $signed({1'b0, shortest_pulse});
  assign span_mag = span[PW] ? PW'(-span) : span[PW-1:0];

  assign div_start = (state == srpg_pkg::S_MAP_START) ||
                     (state == srpg_pkg::S_EVAL && cmd_q == srpg_pkg::CMD_SET &&
                      in_range && diff != '0 && ramp_q != '0);
  assign div_dividend = (state == srpg_pkg::S_MAP_START) ?
                        DW'(product[PRW-1:FRACTION_BITS]) : DW'(diff_mag[CW-1:0]);
  assign div_divisor  = (state == srpg_pkg::S_MAP_START) ?
                        srpg_pkg::RAMP_W'(srpg_pkg::ANGLE_SPAN) : ramp_q;

  assign step_q   = div_quotient[CW-1:0];
  assign step_fix = (step_q == '0) ? CW'(1) : step_q;
  assign map_q    = div_quotient[PW-1:0];

  srpg_serial_div #(
    .DW(DW),
    .VW(srpg_pkg::RAMP_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  assign in_ready = state == srpg_pkg::S_IDLE;
  assign out_load = state == srpg_pkg::S_FINISH && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      lowest_angle   <= srpg_pkg::LOWEST_RESET;
      highest_angle  <= srpg_pkg::HIGHEST_RESET;
      shortest_pulse <= srpg_pkg::SHORTEST_RESET;
      longest_pulse  <= srpg_pkg::LONGEST_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        srpg_pkg::REG_LOWEST:   lowest_angle   <= cfg_data[AW-1:0];
        srpg_pkg::REG_HIGHEST:  highest_angle  <= cfg_data[AW-1:0];
        srpg_pkg::REG_SHORTEST: shortest_pulse <= cfg_data[PW-1:0];
        srpg_pkg::REG_LONGEST:  longest_pulse  <= cfg_data[PW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= srpg_pkg::S_IDLE;
      current_angle <= '0;
      target_angle  <= '0;
      step_per_tick <= '0;
      pulse_now     <= srpg_pkg::PULSE_MID_RESET;
    end else begin
      unique case (state)
        srpg_pkg::S_IDLE: begin
          if (in_valid) begin
            state <= srpg_pkg::S_EVAL;
          end
        end
        srpg_pkg::S_EVAL: begin
          res_status  <= srpg_pkg::STATUS_OK;
          res_written <= 1'b0;
          if (cmd_q == srpg_pkg::CMD_SET) begin
            if (!in_range) begin
              res_status  <= srpg_pkg::STATUS_RANGE;
              res_turning <= !at_target;
              state       <= srpg_pkg::S_FINISH;
            end else begin
              target_angle <= goal_q;
              res_turning  <= diff != '0;
              diff_neg     <= diff[DFW-1];
              if (diff == '0) begin
                step_per_tick <= '0;
                state         <= srpg_pkg::S_FINISH;
              end else if (ramp_q == '0) begin
                step_per_tick <= diff;
                state         <= srpg_pkg::S_FINISH;
              end else begin
                state <= srpg_pkg::S_STEP_DIV;
              end
            end
          end else begin
            if (at_target) begin
              res_turning <= 1'b0;
              state       <= srpg_pkg::S_FINISH;
            end else begin
              current_angle <= next_angle;
              res_turning   <= 1'b1;
              res_written   <= 1'b1;
              state         <= srpg_pkg::S_MAP_OFF;
            end
          end
        end
        srpg_pkg::S_STEP_DIV: begin
          if (div_done) begin
            step_per_tick <= diff_neg ? DFW'(-$signed({1'b0, step_fix}))
                                      : $signed({1'b0, step_fix});
            state         <= srpg_pkg::S_FINISH;
          end
        end
        srpg_pkg::S_MAP_OFF: begin
          off_q <= off_clamped;
          state <= srpg_pkg::S_MAP_MUL;
        end
        srpg_pkg::S_MAP_MUL: begin
          product  <= PRW'(span_mag) * PRW'(off_q);
          span_neg <= span[PW];
          state    <= srpg_pkg::S_MAP_START;
        end
        srpg_pkg::S_MAP_START: begin
          state <= srpg_pkg::S_MAP_DIV;
        end
        srpg_pkg::S_MAP_DIV: begin
          if (div_done) begin
            pulse_now <= span_neg ? shortest_pulse - map_q : shortest_pulse + map_q;
            state     <= srpg_pkg::S_FINISH;
          end
        end
        srpg_pkg::S_FINISH: begin
          if (out_load) begin
            state <= srpg_pkg::S_IDLE;
          end
        end
        default: state <= srpg_pkg::S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_q  <= command;
      goal_q <= goal_angle;
      ramp_q <= ramp_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status        <= res_status;
      pulse_length  <= pulse_now;
      turning       <= res_turning;
      pulse_written <= res_written;
    end
  end

endmodule

>>> rtl/srpg_checker.sv
// Port checker of the servo ramp pulse generator and its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module srpg_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         status,
  input logic [srpg_pkg::PULSE_W-1:0] pulse_length,
  input logic                         turning,
  input logic                         pulse_written
);

  `SRPG_ASSERT(a_busy_after_accept, clk, rst, in_valid && in_ready |=> !in_ready)
  `SRPG_ASSERT(a_written_is_turning, clk, rst, out_valid && pulse_written |-> turning)
  `SRPG_ASSERT(a_refused_no_write, clk, rst, out_valid && status |-> !pulse_written)
  `SRPG_ASSERT(a_stall_holds, clk, rst,
    out_valid && !out_ready |=> out_valid && $stable(pulse_length))
  `SRPG_ASSERT_ALWAYS(a_reset_empties, clk, rst |=> !out_valid)

endmodule

bind servo_ramp_pulse_generator srpg_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .status        (status),
  .pulse_length  (pulse_length),
  .turning       (turning),
  .pulse_written (pulse_written)
);
